// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL core of the transcoder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant violated");

// A condition that, once seen, forces another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule violated");

`endif

// ===== rtl/u16u8_pkg.sv =====
// ---------------------------------------------------------------------------
// u16u8_pkg
// Constants and register codes for the UTF-16 to UTF-8 transcoder.
// ---------------------------------------------------------------------------
package u16u8_pkg;

    // Width of the per-string byte and unit counters.
    localparam int COUNT_BITS = 16;
    // Counter width plus one carry bit, for the byte-count sum.
    localparam int SUM_BITS   = COUNT_BITS + 1;
    // Common width for comparing counters against 16-bit registers.
    localparam int CMP_BITS   = (SUM_BITS > 17) ? SUM_BITS : 17;

    localparam int CFG_W      = 16;
    localparam int UNIT_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;

    // Result buffer: up to three bytes plus a closing result.
    localparam int SLOTS      = 4;
    localparam int SLOT_W     = 2;
    localparam int NRES_W     = 3;

    typedef enum logic {
        CFG_OUT_CAPACITY = 1'b0,
        CFG_MAX_UNITS    = 1'b1
    } cfg_index_t;

    localparam logic [CFG_W-1:0] OUT_CAPACITY_RST = 16'd256;
    localparam logic [CFG_W-1:0] MAX_UNITS_RST    = 16'd256;

    localparam logic [UNIT_W-1:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [UNIT_W-1:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [BYTE_W-1:0] LEAD2_MARK     = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MARK     = 8'hE0;
    localparam logic [BYTE_W-1:0] CONT_MARK      = 8'h80;
    localparam logic [5:0]        CONT_MASK      = 6'h3F;

endpackage

// ===== rtl/utf16_to_utf8_transcoder_core.sv =====
// ---------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// Streams UTF-16 code units in and UTF-8 bytes out, one byte per transfer,
// with a closing transfer that reports the byte count of each string.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_*       in         tdata[15:0] code_unit, tlast final_unit
//  m_*       out        tdata[7:0] out_byte, tdata[23:8] bytes_written,
//                       tuser is_terminator, tlast is_closing
//  cfg_*     in         cfg_addr 0 out_capacity, 1 max_units, 16-bit data
//
//  A code unit waits in the input register and is then encoded
//  combinationally into the result buffer; the buffer drains one transfer
//  per cycle while m_tready is high, one per byte of the unit and one more
//  when it closes. The byte-wide result port limits the sustained rate, most
//  of all for text above U+07FF. Units that produce no result make no transfer.
//  Reset is synchronous, active low; it clears counters, valid flags and
//  restores both registers to 256. No clearing pass is needed.
//  A stall on m_tready holds the buffer; one further unit waits in the
//  input register before s_tready drops.
//
`include "assert_macros.svh"

module utf16_to_utf8_transcoder_core (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic                             cfg_addr,
    input  logic [u16u8_pkg::CFG_W-1:0]      cfg_wdata,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [u16u8_pkg::S_DATA_W-1:0]   s_tdata,    // [15:0] code_unit
    input  logic                             s_tlast,    // final_unit

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [u16u8_pkg::M_DATA_W-1:0]   m_tdata,    // [7:0] out_byte, [23:8] bytes_written
    output logic                             m_tuser,    // is_terminator
    output logic                             m_tlast     // is_closing
);

    localparam int CB = u16u8_pkg::COUNT_BITS;
    localparam int SB = u16u8_pkg::SUM_BITS;
    localparam int KB = u16u8_pkg::CMP_BITS;

    // Configuration registers.
    logic [u16u8_pkg::CFG_W-1:0] out_capacity_reg;
    logic [u16u8_pkg::CFG_W-1:0] max_units_reg;

    // Input register holding one accepted code unit.
    logic                              item_valid_reg;
    logic [u16u8_pkg::UNIT_W-1:0]      item_unit_reg;
    logic                              item_final_reg;

    // Per-string conversion state.
    logic [CB-1:0] byte_count_reg, byte_count_next;
    logic [CB-1:0] unit_count_reg, unit_count_next;
    logic          halted_reg, halted_next;

    // Result buffer: the results caused by one unit, drained in order.
    logic [u16u8_pkg::BYTE_W-1:0] buf_byte_reg [u16u8_pkg::SLOTS];
    logic [u16u8_pkg::BYTE_W-1:0] buf_byte_next [u16u8_pkg::SLOTS];
    logic [u16u8_pkg::NRES_W-1:0] buf_cnt_reg, buf_cnt_next;
    logic [u16u8_pkg::SLOT_W-1:0] buf_idx_reg;
    logic                         buf_valid_reg;
    logic                         buf_close_reg, buf_close_next;
    logic                         buf_term_reg, buf_term_next;
    logic [15:0]                  buf_bw_reg, buf_bw_next;

    logic                         buf_last;
    logic                         buf_done;
    logic                         load;

    // Encoder signals.
    logic [1:0]    n_bytes;
    logic [SB-1:0] sum;
    logic          stop_unit;
    logic          stop_room;
    logic          convert;
    logic [KB-1:0] final_count_ext;

    // The last buffered result is the one at index count - 1.
    assign buf_last = ({1'b0, buf_idx_reg} == (buf_cnt_reg - 1'b1));
    assign buf_done = buf_valid_reg && m_tready && buf_last;

    // The unit in the input register moves on once the buffer is free or
    // its final result is being transferred this cycle.
    assign load     = item_valid_reg && (!buf_valid_reg || buf_done);
    assign s_tready = !item_valid_reg || load;

    // -----------------------------------------------------------------------
    // Encoder: decides whether the unit is converted, builds its bytes and,
    // for a final unit, the closing result.
    // -----------------------------------------------------------------------
    always_comb begin
        if (item_unit_reg < u16u8_pkg::ONE_BYTE_LIMIT) begin
            n_bytes = 2'd1;
        end else if (item_unit_reg < u16u8_pkg::TWO_BYTE_LIMIT) begin
            n_bytes = 2'd2;
        end else begin
            n_bytes = 2'd3;
        end

        sum = {1'b0, byte_count_reg} + SB'(n_bytes);

        stop_unit = (KB'(unit_count_reg) >= KB'(max_units_reg))
                 || (unit_count_reg == {CB{1'b1}})
                 || (item_unit_reg == '0);
        stop_room = (KB'(sum) >= KB'(out_capacity_reg)) || sum[CB];
        convert   = !halted_reg && !stop_unit && !stop_room;

        byte_count_next = byte_count_reg;
        unit_count_next = unit_count_reg;
        halted_next     = halted_reg;
        if (!halted_reg) begin
            if (convert) begin
                byte_count_next = sum[CB-1:0];
                unit_count_next = unit_count_reg + 1'b1;
            end else begin
                halted_next = 1'b1;
            end
        end

        for (int i = 0; i < u16u8_pkg::SLOTS; i++) begin
            buf_byte_next[i] = '0;
        end
        buf_cnt_next = '0;
        if (convert) begin
            unique case (n_bytes)
                2'd1: begin
                    buf_byte_next[0] = item_unit_reg[7:0];
                end
                2'd2: begin
                    buf_byte_next[0] = u16u8_pkg::LEAD2_MARK
                                     | {3'b000, item_unit_reg[10:6]};
                    buf_byte_next[1] = u16u8_pkg::CONT_MARK
                                     | {2'b00, item_unit_reg[5:0] & u16u8_pkg::CONT_MASK};
                end
                default: begin
                    buf_byte_next[0] = u16u8_pkg::LEAD3_MARK
                                     | {4'b0000, item_unit_reg[15:12]};
                    buf_byte_next[1] = u16u8_pkg::CONT_MARK
                                     | {2'b00, item_unit_reg[11:6] & u16u8_pkg::CONT_MASK};
                    buf_byte_next[2] = u16u8_pkg::CONT_MARK
                                     | {2'b00, item_unit_reg[5:0] & u16u8_pkg::CONT_MASK};
                end
            endcase
            buf_cnt_next = {1'b0, n_bytes};
        end

        // The closing result reports the count after this unit, and a
        // terminator only if a byte of room is left below the capacity.
        final_count_ext = KB'(byte_count_next);
        buf_close_next  = item_final_reg;
        buf_term_next   = final_count_ext < KB'(out_capacity_reg);
        buf_bw_next     = final_count_ext[15:0];
        if (item_final_reg) begin
            buf_cnt_next = buf_cnt_next + 1'b1;
            byte_count_next = '0;
            unit_count_next = '0;
            halted_next     = 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Registers.
    // -----------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_capacity_reg <= u16u8_pkg::OUT_CAPACITY_RST;
            max_units_reg    <= u16u8_pkg::MAX_UNITS_RST;
            item_valid_reg   <= 1'b0;
            byte_count_reg   <= '0;
            unit_count_reg   <= '0;
            halted_reg       <= 1'b0;
            buf_valid_reg    <= 1'b0;
            buf_idx_reg      <= '0;
            buf_cnt_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    u16u8_pkg::CFG_OUT_CAPACITY: out_capacity_reg <= cfg_wdata;
                    u16u8_pkg::CFG_MAX_UNITS:    max_units_reg    <= cfg_wdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                item_valid_reg <= 1'b1;
            end else if (load) begin
                item_valid_reg <= 1'b0;
            end

            if (load) begin
                byte_count_reg <= byte_count_next;
                unit_count_reg <= unit_count_next;
                halted_reg     <= halted_next;
                buf_valid_reg  <= (buf_cnt_next != '0);
                buf_cnt_reg    <= buf_cnt_next;
                buf_idx_reg    <= '0;
            end else if (buf_done) begin
                buf_valid_reg  <= 1'b0;
            end else if (buf_valid_reg && m_tready) begin
                buf_idx_reg    <= buf_idx_reg + 1'b1;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_unit_reg  <= s_tdata[u16u8_pkg::UNIT_W-1:0];
            item_final_reg <= s_tlast;
        end
        if (load) begin
            buf_byte_reg  <= buf_byte_next;
            buf_close_reg <= buf_close_next;
            buf_term_reg  <= buf_term_next;
            buf_bw_reg    <= buf_bw_next;
        end
    end

    // -----------------------------------------------------------------------
    // Result channel. Byte results carry a zero count and no flags; the
    // closing result is always the last entry of the buffer.
    // -----------------------------------------------------------------------
    assign m_tvalid = buf_valid_reg;
    assign m_tlast  = buf_close_reg && buf_last;
    assign m_tuser  = m_tlast && buf_term_reg;
    assign m_tdata  = {(m_tlast ? buf_bw_reg : 16'h0000), buf_byte_reg[buf_idx_reg]};

    // -----------------------------------------------------------------------
    // Assertions.
    // -----------------------------------------------------------------------
    `ASSERT_ALWAYS(a_idx_in_range, aclk, aresetn,
        !buf_valid_reg || ({1'b0, buf_idx_reg} < buf_cnt_reg))
    `ASSERT_NEXT(a_final_clears, aclk, aresetn, load && item_final_reg,
        (byte_count_reg == '0) && (unit_count_reg == '0) && !halted_reg)
    `ASSERT_ALWAYS(a_stall_needs_item, aclk, aresetn, s_tready || item_valid_reg)
    `ASSERT_NEXT(a_idle_halt_no_bytes, aclk, aresetn,
        load && halted_reg && !item_final_reg, !buf_valid_reg)

endmodule
